// ===== rtl/dnsaaa_pkg.sv =====
// Shared types and constants for the DNS A-to-AAAA answer synthesizer.
package dnsaaa_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	// Emit command: the back end plays byte positions start..15 of a
	// sixteen-position frame (0..7 prefix_upper, 8..11 prefix_lower,
	// 12..14 held address bytes, 15 the current byte).
	typedef struct packed {
		logic [3:0]  start;
		logic [7:0]  data;
		logic        last;
		logic [23:0] hold;
	} cmd_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] POS_FIRST    = 4'd0;
	localparam logic [3:0] POS_ADDR_HI  = 4'd12;
	localparam logic [3:0] POS_ADDR_MID = 4'd13;
	localparam logic [3:0] POS_ADDR_LO  = 4'd14;
	localparam logic [3:0] POS_CURRENT  = 4'd15;

	localparam logic       REG_PREFIX_UPPER = 1'b0;
	localparam logic       REG_PREFIX_LOWER = 1'b1;
	localparam logic [63:0] PREFIX_UPPER_RESET = 64'h0;
	localparam logic [31:0] PREFIX_LOWER_RESET = 32'h0000_ffff;

endpackage

// ===== rtl/dnsaaa_front.sv =====
// Front end: parses the DNS response byte stream and queues emit commands.
module dnsaaa_front
	import dnsaaa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t in_item,
	output logic     push,
	output cmd_t     cmd
);

	localparam logic [3:0] PH_HEADER = 4'd0;
	localparam logic [3:0] PH_QLEN   = 4'd1;
	localparam logic [3:0] PH_QLABEL = 4'd2;
	localparam logic [3:0] PH_QFIXED = 4'd3;
	localparam logic [3:0] PH_ALEN   = 4'd4;
	localparam logic [3:0] PH_ALABEL = 4'd5;
	localparam logic [3:0] PH_APTR   = 4'd6;
	localparam logic [3:0] PH_AFIXED = 4'd7;
	localparam logic [3:0] PH_ADDR   = 4'd8;
	localparam logic [3:0] PH_RDATA  = 4'd9;
	localparam logic [3:0] PH_TRAIL  = 4'd10;

	localparam logic [3:0] HEADER_LEN  = 4'd12;
	localparam logic [3:0] QFIXED_LEN  = 4'd4;
	localparam logic [3:0] AFIXED_LEN  = 4'd10;
	localparam logic [7:0] PTR_MASK    = 8'hc0;
	localparam logic [7:0] TYPE_AAAA   = 8'd28;
	localparam logic [7:0] RDLEN_AAAA  = 8'd16;
	localparam logic [15:0] RDLEN_A    = 16'd4;

	logic [3:0]  phase_q, phase_d;
	logic [3:0]  fidx_q, fidx_d;
	logic [15:0] qleft_q, qleft_d;
	logic [15:0] aleft_q, aleft_d;
	logic [7:0]  lleft_q, lleft_d;
	logic [15:0] rdleft_q, rdleft_d;
	logic        is_a_q, is_a_d;
	logic        thz_q, thz_d;
	logic [23:0] hold_q, hold_d;

	logic [7:0]  b;
	logic [7:0]  ob;
	logic [3:0]  fidx_inc;
	logic [15:0] qleft_dec;
	logic [15:0] aleft_dec;
	logic [7:0]  lleft_dec;
	logic [15:0] rdleft_dec;
	logic [15:0] rd_full;
	logic        emit;
	logic [3:0]  start;
	logic [23:0] cmd_hold;

	assign b          = in_item.in_byte;
	assign fidx_inc   = fidx_q + 4'd1;
	assign qleft_dec  = qleft_q - 16'd1;
	assign aleft_dec  = aleft_q - 16'd1;
	assign lleft_dec  = lleft_q - 8'd1;
	assign rdleft_dec = rdleft_q - 16'd1;
	assign rd_full    = {rdleft_q[15:8], b};

	always_comb begin
		phase_d  = phase_q;
		fidx_d   = fidx_q;
		qleft_d  = qleft_q;
		aleft_d  = aleft_q;
		lleft_d  = lleft_q;
		rdleft_d = rdleft_q;
		is_a_d   = is_a_q;
		thz_d    = thz_q;
		hold_d   = hold_q;
		ob       = b;
		emit     = 1'b1;
		start    = POS_CURRENT;
		cmd_hold = hold_q;
		case (phase_q)
			PH_HEADER: begin
				if (fidx_q == 4'd4) qleft_d = {b, 8'h00};
				else if (fidx_q == 4'd5) qleft_d = {qleft_q[15:8], b};
				else if (fidx_q == 4'd6) aleft_d = {b, 8'h00};
				else if (fidx_q == 4'd7) aleft_d = {aleft_q[15:8], b};
				fidx_d = fidx_inc;
				if (fidx_inc >= HEADER_LEN) begin
					fidx_d = 4'd0;
					if (qleft_q != 16'd0) phase_d = PH_QLEN;
					else phase_d = (aleft_q != 16'd0) ? PH_ALEN : PH_TRAIL;
				end
			end
			PH_QLEN: begin
				if (b == 8'd0) begin
					phase_d = PH_QFIXED;
					fidx_d  = 4'd0;
				end else begin
					lleft_d = b;
					phase_d = PH_QLABEL;
				end
			end
			PH_QLABEL: begin
				lleft_d = lleft_dec;
				if (lleft_dec == 8'd0) phase_d = PH_QLEN;
			end
			PH_QFIXED: begin
				fidx_d = fidx_inc;
				if (fidx_inc >= QFIXED_LEN) begin
					fidx_d  = 4'd0;
					qleft_d = qleft_dec;
					if (qleft_dec != 16'd0) phase_d = PH_QLEN;
					else phase_d = (aleft_q != 16'd0) ? PH_ALEN : PH_TRAIL;
				end
			end
			PH_ALEN: begin
				if ((b & PTR_MASK) != 8'd0) begin
					phase_d = PH_APTR;
				end else if (b == 8'd0) begin
					phase_d = PH_AFIXED;
					fidx_d  = 4'd0;
				end else begin
					lleft_d = b;
					phase_d = PH_ALABEL;
				end
			end
			PH_ALABEL: begin
				lleft_d = lleft_dec;
				if (lleft_dec == 8'd0) phase_d = PH_ALEN;
			end
			PH_APTR: begin
				phase_d = PH_AFIXED;
				fidx_d  = 4'd0;
			end
			PH_AFIXED: begin
				if (fidx_q == 4'd0) begin
					thz_d = (b == 8'd0);
				end else if (fidx_q == 4'd1) begin
					is_a_d = thz_q && (b == 8'd1);
					if (is_a_d) ob = TYPE_AAAA;
				end else if (fidx_q == 4'd8) begin
					rdleft_d = {b, 8'h00};
				end else if (fidx_q == 4'd9) begin
					rdleft_d = rd_full;
					if (is_a_q && rd_full == RDLEN_A) ob = RDLEN_AAAA;
				end
				fidx_d = fidx_inc;
				if (fidx_inc >= AFIXED_LEN) begin
					fidx_d = 4'd0;
					if (is_a_d && rdleft_d == RDLEN_A) begin
						phase_d = PH_ADDR;
						hold_d  = 24'd0;
					end else if (rdleft_d == 16'd0) begin
						aleft_d = aleft_dec;
						phase_d = (aleft_dec != 16'd0) ? PH_ALEN : PH_TRAIL;
					end else begin
						phase_d = PH_RDATA;
					end
				end
			end
			PH_ADDR: begin
				if (in_item.in_last) begin
					// flush the held bytes unchanged, then this one
					start = POS_CURRENT - fidx_q;
				end else if (fidx_q < 4'd3) begin
					emit   = 1'b0;
					hold_d = {hold_q[15:0], b};
					fidx_d = fidx_inc;
				end else begin
					start   = POS_FIRST;
					fidx_d  = 4'd0;
					aleft_d = aleft_dec;
					phase_d = (aleft_dec != 16'd0) ? PH_ALEN : PH_TRAIL;
				end
			end
			PH_RDATA: begin
				rdleft_d = rdleft_dec;
				if (rdleft_dec == 16'd0) begin
					aleft_d = aleft_dec;
					phase_d = (aleft_dec != 16'd0) ? PH_ALEN : PH_TRAIL;
				end
			end
			default: begin
			end
		endcase
		// end of packet: return all parse state to reset
		if (in_item.in_last) begin
			phase_d  = PH_HEADER;
			fidx_d   = 4'd0;
			qleft_d  = 16'd0;
			aleft_d  = 16'd0;
			lleft_d  = 8'd0;
			rdleft_d = 16'd0;
			is_a_d   = 1'b0;
			thz_d    = 1'b0;
			hold_d   = 24'd0;
		end
	end

	assign push = accept && emit;
	assign cmd  = '{start: start, data: ob, last: in_item.in_last, hold: cmd_hold};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			fidx_q   <= 4'd0;
			qleft_q  <= 16'd0;
			aleft_q  <= 16'd0;
			lleft_q  <= 8'd0;
			rdleft_q <= 16'd0;
			is_a_q   <= 1'b0;
			thz_q    <= 1'b0;
			hold_q   <= 24'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			fidx_q   <= fidx_d;
			qleft_q  <= qleft_d;
			aleft_q  <= aleft_d;
			lleft_q  <= lleft_d;
			rdleft_q <= rdleft_d;
			is_a_q   <= is_a_d;
			thz_q    <= thz_d;
			hold_q   <= hold_d;
		end
	end

endmodule

// ===== rtl/dnsaaa_queue.sv =====
// Small command queue between the parsing front end and the emitting back end.
module dnsaaa_queue
	import dnsaaa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t                   slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/dnsaaa_back.sv =====
// Back end: plays each queued command out as result bytes into an output register.
module dnsaaa_back
	import dnsaaa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] prefix_upper,
	input  logic [31:0] prefix_lower,
	input  logic        head_valid,
	input  cmd_t        head_cmd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	logic      active_q;
	logic [3:0] pos_q;
	logic      out_valid_q;
	out_item_t out_item_q;

	logic [3:0] pos;
	logic       load;
	logic [7:0] sel_byte;

	assign pos  = active_q ? pos_q : head_cmd.start;
	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && (pos == POS_CURRENT);

	always_comb begin
		case (pos)
			POS_ADDR_HI:  sel_byte = head_cmd.hold[23:16];
			POS_ADDR_MID: sel_byte = head_cmd.hold[15:8];
			POS_ADDR_LO:  sel_byte = head_cmd.hold[7:0];
			POS_CURRENT:  sel_byte = head_cmd.data;
			default: begin
				if (!pos[3]) sel_byte = prefix_upper[{~pos[2:0], 3'b000} +: 8];
				else sel_byte = prefix_lower[{~pos[1:0], 3'b000} +: 8];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pos_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (pos == POS_CURRENT) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					pos_q    <= pos + 4'd1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q.out_byte <= sel_byte;
			out_item_q.out_last <= head_cmd.last && (pos == POS_CURRENT);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== rtl/dns_answer_a_to_aaaa_synthesizer.sv =====
// Top level of the DNS A-to-AAAA answer synthesizer.
// Rewrites an IPv4-side DNS response, one byte per transaction, into its IPv6-side
// form. The header (counts left as they are), questions and trailing sections pass
// through byte for byte. In each answer a type A (0x0001) becomes type AAAA (28);
// if its RDLENGTH is 4 the length goes out as 16 and the four address bytes are
// replaced by sixteen: the 96-bit prefix from prefix_upper (bytes 0..7, byte 0 in
// bits 63:56) and prefix_lower (bytes 8..11), then the IPv4 address. in_last
// closes a packet and restarts parsing at a new header; if it lands inside a held
// address, the held bytes go out unchanged ahead of it. Rate: the block takes one
// byte per cycle while the queue has room and delivers one byte per cycle while
// out_ready allows; a pass-through byte gives one output byte, an expanded address
// four inputs for sixteen outputs. The output side sets the pace: a four-entry
// command queue lets the parser run ahead of the emitter, and a full queue stalls
// in_ready. Write the prefix registers only while no packet is in flight.
module dns_answer_a_to_aaaa_synthesizer
	import dnsaaa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_index,
	input  logic [63:0] cfg_wr_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic [63:0] prefix_upper_q;
	logic [31:0] prefix_lower_q;

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic full;
	logic head_valid;
	cmd_t head_cmd;

	// Configuration: plain register writes, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_upper_q <= PREFIX_UPPER_RESET;
			prefix_lower_q <= PREFIX_LOWER_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PREFIX_UPPER: prefix_upper_q <= cfg_wr_data;
				REG_PREFIX_LOWER: prefix_lower_q <= cfg_wr_data[31:0];
				default:          prefix_upper_q <= prefix_upper_q;
			endcase
		end
	end

	// Accept a byte whenever the command queue has room; bytes that only fill
	// the address hold push nothing.
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	dnsaaa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_item (in_item),
		.push    (push),
		.cmd     (push_cmd)
	);

	dnsaaa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Advance through each command's byte positions, one result per cycle while out_ready allows.
	dnsaaa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.prefix_upper (prefix_upper_q),
		.prefix_lower (prefix_lower_q),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item)
	);

endmodule
